>>> rtl/sls_pkg.sv
// sls_pkg: token kinds, result record type and keyword table of the source lexical scanner
// no dependencies; used by source_lexical_scanner
`default_nettype none

package sls_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int KEYWORD_COUNT_DEF = 24;

  localparam int KW_TABLE = 24;
  localparam int KW_FIRST = 25;
  localparam int KW_CHARS = 12;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_EOL     = 6'd1;
  localparam logic [5:0] K_UNDEF   = 6'd2;
  localparam logic [5:0] K_COMMENT = 6'd3;
  localparam logic [5:0] K_STRING  = 6'd4;
  localparam logic [5:0] K_NUMBER  = 6'd5;
  localparam logic [5:0] K_IDENT   = 6'd6;
  localparam logic [5:0] K_LPAREN  = 6'd7;
  localparam logic [5:0] K_RPAREN  = 6'd8;
  localparam logic [5:0] K_SEMI    = 6'd9;
  localparam logic [5:0] K_PLUS    = 6'd10;
  localparam logic [5:0] K_MINUS   = 6'd11;
  localparam logic [5:0] K_STAR    = 6'd12;
  localparam logic [5:0] K_SLASH   = 6'd13;
  localparam logic [5:0] K_CARET   = 6'd14;
  localparam logic [5:0] K_EQUAL   = 6'd15;
  localparam logic [5:0] K_HASH    = 6'd16;
  localparam logic [5:0] K_AMP     = 6'd17;
  localparam logic [5:0] K_BAR     = 6'd18;
  localparam logic [5:0] K_PCT     = 6'd19;
  localparam logic [5:0] K_LT      = 6'd20;
  localparam logic [5:0] K_LE      = 6'd21;
  localparam logic [5:0] K_GT      = 6'd22;
  localparam logic [5:0] K_GE      = 6'd23;
  localparam logic [5:0] K_ASSIGN  = 6'd24;

  typedef struct packed {
    logic [5:0]  kind;
    logic        is_error;
    logic [23:0] offset;
    logic [23:0] length;
    logic        any_error;
    logic        last;
  } tok_t;

  // keyword text right-justified, zero padded on the left
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_TABLE] = '{
    "BEGIN", "END", "ENDPROCEDURE", "ENDFUNCTION", "ENDIF", "ENDWHILE",
    "ENDLOOP", "ENDPLOOP", "ENDFIT", "ENDSCOPE", "FIT", "FUNCTION", "IF",
    "INCLUDE", "LOOP", "PLOOP", "PROCEDURE", "READ", "SAVE", "SCOPE",
    "VARIABLE", "WHILE", "WRITE", "ELSEIF"
  };

  localparam int KW_LEN [KW_TABLE] = '{
    5, 3, 12, 11, 5, 8, 7, 8, 6, 8, 3, 8, 2, 7, 4, 5, 9, 4, 4, 5, 8, 5, 5, 6
  };

  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [7:0] ch;
    ch = 8'd0;
    if (k < KW_TABLE) begin
      if (i < KW_LEN[k]) begin
        ch = KW_TEXT[k][(KW_LEN[k]-1-i)*8 +: 8];
      end
    end
    return ch;
  endfunction

  // single-character symbol lookup: hit flag and kind
  function automatic logic [6:0] sym_lookup(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h3B:   r = {1'b1, K_SEMI};
      8'h2B:   r = {1'b1, K_PLUS};
      8'h2D:   r = {1'b1, K_MINUS};
      8'h2A:   r = {1'b1, K_STAR};
      8'h2F:   r = {1'b1, K_SLASH};
      8'h5E:   r = {1'b1, K_CARET};
      8'h3D:   r = {1'b1, K_EQUAL};
      8'h23:   r = {1'b1, K_HASH};
      8'h26:   r = {1'b1, K_AMP};
      8'h7C:   r = {1'b1, K_BAR};
      8'h25:   r = {1'b1, K_PCT};
      default: r = {1'b0, K_EOF};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/source_lexical_scanner.sv
// source_lexical_scanner: byte-stream lexer producing kind, offset and length tokens
// depends on sls_pkg for token kinds, the result record and the keyword table
`default_nettype none

// a token is written into the result queue register on the transfer of the byte that
//   completes it; throughput is one byte per cycle while results drain as fast
// a byte yields up to three tokens, held in a four-entry result queue; in_tready drops
//   while fewer than three entries are free, so a burst of tokens can stall input
// reset (rst_n low, synchronous) empties the queue, clears position, start and error
//   flag, loads all keyword candidates and returns the scanner to idle

module source_lexical_scanner
  import sls_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [23:0] offset, [47:24] length, [48] any_error, rest zero
  output logic [6:0]       out_tuser,  // [5:0] kind, [6] is_error
  output logic             out_tlast
);

  localparam int PB = POSITION_BITS;
  localparam int KC = KEYWORD_COUNT;
  localparam int XW = POSITION_BITS + 24;   // wide enough for wrap to 24 bits

  // scanner modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_NUMDOT  = 4'd3;
  localparam logic [3:0] M_LT      = 4'd4;
  localparam logic [3:0] M_GT      = 4'd5;
  localparam logic [3:0] M_COLON   = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_STRING  = 4'd8;
  localparam logic [3:0] M_HALT    = 4'd9;

  localparam logic [PB-1:0] POS_MAX = '1;

  logic [3:0]    mode_r, mode_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] ts_r, ts_nxt;
  logic [KC-1:0] cand_r, cand_nxt;
  logic          err_r, err_nxt;

  tok_t          res [3];
  logic [1:0]    res_n;

  // result queue
  tok_t          q_r [4];
  logic [1:0]    wp_r, rp_r;
  logic [2:0]    cnt_r;

  logic          in_xfer, out_xfer;
  logic [7:0]    c;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign c        = in_tdata;

  function automatic logic [23:0] to24(input logic [XW-1:0] x);
    return x[23:0];
  endfunction

  function automatic logic [XW-1:0] ext(input logic [PB-1:0] x);
    return {{24{1'b0}}, x};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) ? b - 8'd32 : b;
  endfunction

  // drop every candidate whose character at idx differs from the byte
  function automatic logic [KC-1:0] filt(input logic [KC-1:0] cand, input logic [7:0] b,
                                         input logic [PB-1:0] idx);
    logic [KC-1:0] r;
    logic [7:0]    ub;
    r  = '0;
    ub = upcase(b);
    for (int k = 0; k < KC; k++) begin
      if (cand[k] && (k < KW_TABLE) && (idx < PB'(KW_CHARS))) begin
        if ((int'(idx) < KW_LEN[k]) && (kw_char(k, int'(idx)) == ub)) begin
          r[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // lowest surviving keyword whose length matches, else plain identifier
  function automatic logic [5:0] ident_kind(input logic [KC-1:0] cand,
                                            input logic [PB-1:0] len);
    logic [5:0] kd;
    kd = K_IDENT;
    for (int k = KC - 1; k >= 0; k--) begin
      if (cand[k] && (k < KW_TABLE) && (len <= PB'(KW_CHARS))) begin
        if (int'(len) == KW_LEN[k]) begin
          kd = 6'(KW_FIRST + k);
        end
      end
    end
    return kd;
  endfunction

  // token decode for one byte
  always_comb begin
    logic [XW-1:0] p_x, ts_x, span;
    logic          disp;
    logic [6:0]    sym;
    tok_t          t;

    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    cand_nxt = cand_r;
    err_nxt  = err_r;
    res_n    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    p_x  = ext(pos_r);
    ts_x = ext(ts_r);
    span = p_x - ts_x;
    disp = 1'b0;
    sym  = sym_lookup(c);
    t    = '0;

    if (c == 8'd0) begin
      // end of source: flush the open token, then the end-of-file token unless a string was open or scanning had halted
      case (mode_r)
        M_IDENT: begin
          t = '{ident_kind(cand_r, pos_r - ts_r), 1'b0, to24(ts_x), to24(span), 1'b0, 1'b0};
          res[res_n] = t; res_n = res_n + 2'd1;
        end
        M_NUMBER: begin
          res[res_n] = '{K_NUMBER, 1'b0, to24(ts_x), to24(span), 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_NUMDOT: begin
          res[res_n] = '{K_UNDEF, 1'b1, to24(ts_x), to24(span), 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_LT: begin
          res[res_n] = '{K_LT, 1'b0, to24(ts_x), 24'd1, 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_GT: begin
          res[res_n] = '{K_GT, 1'b0, to24(ts_x), 24'd1, 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_COLON: begin
          res[res_n] = '{K_UNDEF, 1'b1, to24(ts_x), 24'd1, 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_COMMENT: begin
          // unterminated comment: error, then the comment body
          res[res_n] = '{K_EOF, 1'b1, to24(ts_x), to24(span), 1'b0, 1'b0};
          res_n = res_n + 2'd1;
          res[res_n] = '{K_COMMENT, 1'b0, to24(ts_x + XW'(1)), to24(span - XW'(1)),
                         1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end
        M_STRING: begin
          res[res_n] = '{K_EOF, 1'b1, to24(ts_x), to24(span), 1'b1, 1'b0};
          res_n = res_n + 2'd1;
        end
        default: begin
        end
      endcase
      if ((mode_r != M_HALT) && (mode_r != M_STRING)) begin
        res[res_n] = '{K_EOF, 1'b0, to24(p_x), 24'd0,
                       err_r || (mode_r == M_NUMDOT) || (mode_r == M_COLON) ||
                       (mode_r == M_COMMENT), 1'b0};
        res_n = res_n + 2'd1;
      end
      // new source begins
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      cand_nxt = '1;
      err_nxt  = 1'b0;
    end else begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == 8'h5F)) begin
            cand_nxt = filt(cand_r, c, pos_r - ts_r);
          end else begin
            res[res_n] = '{ident_kind(cand_r, pos_r - ts_r), 1'b0, to24(ts_x), to24(span),
                           1'b0, 1'b0};
            res_n = res_n + 2'd1;
            disp = 1'b1;
          end
        end
        M_NUMBER: begin
          if (c == 8'h2E) begin
            mode_nxt = M_NUMDOT;
          end else if (!is_digit(c)) begin
            res[res_n] = '{K_NUMBER, 1'b0, to24(ts_x), to24(span), 1'b0, 1'b0};
            res_n = res_n + 2'd1;
            disp = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) begin
            mode_nxt = M_NUMBER;
          end else begin
            res[res_n] = '{K_UNDEF, 1'b1, to24(ts_x), to24(span), 1'b0, 1'b0};
            res_n = res_n + 2'd1;
            disp = 1'b1;
          end
        end
        M_LT, M_GT: begin
          if (c == 8'h3D) begin
            res[res_n] = '{(mode_r == M_LT) ? K_LE : K_GE, 1'b0, to24(ts_x), 24'd2,
                           1'b0, 1'b0};
            res_n = res_n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[res_n] = '{(mode_r == M_LT) ? K_LT : K_GT, 1'b0, to24(ts_x), 24'd1,
                           1'b0, 1'b0};
            res_n = res_n + 2'd1;
            disp = 1'b1;
          end
        end
        M_COLON: begin
          if (c == 8'h3D) begin
            res[res_n] = '{K_ASSIGN, 1'b0, to24(ts_x), 24'd2, 1'b0, 1'b0};
            res_n = res_n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[res_n] = '{K_UNDEF, 1'b1, to24(ts_x), 24'd1, 1'b0, 1'b0};
            res_n = res_n + 2'd1;
            disp = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == 8'h7D) begin
            res[res_n] = '{K_COMMENT, 1'b0, to24(ts_x + XW'(1)), to24(span - XW'(1)),
                           1'b0, 1'b0};
            res_n = res_n + 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_STRING: begin
          if (c == 8'h27) begin
            res[res_n] = '{K_STRING, 1'b0, to24(ts_x + XW'(1)), to24(span - XW'(1)),
                           1'b0, 1'b0};
            res_n = res_n + 2'd1;
            mode_nxt = M_IDLE;
          end else if ((c == 8'h0D) || (c == 8'h0A)) begin
            // line break inside a string stops scanning until end of source
            res[res_n] = '{K_EOL, 1'b1, to24(ts_x), to24(span), 1'b1, 1'b0};
            res_n = res_n + 2'd1;
            mode_nxt = M_HALT;
          end
        end
        M_HALT: begin
        end
        default: begin
          disp = 1'b1;
        end
      endcase

      // start of a new token on this byte
      if (disp) begin
        mode_nxt = M_IDLE;
        if (sym[6]) begin
          res[res_n] = '{sym[5:0], 1'b0, to24(p_x), 24'd1, 1'b0, 1'b0};
          res_n = res_n + 2'd1;
        end else if (!((c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A))) begin
          ts_nxt = pos_r;
          if (c == 8'h3C) begin
            mode_nxt = M_LT;
          end else if (c == 8'h3E) begin
            mode_nxt = M_GT;
          end else if (c == 8'h3A) begin
            mode_nxt = M_COLON;
          end else if (c == 8'h7B) begin
            mode_nxt = M_COMMENT;
          end else if (c == 8'h27) begin
            mode_nxt = M_STRING;
          end else if (is_digit(c)) begin
            mode_nxt = M_NUMBER;
          end else if (is_alpha(c)) begin
            mode_nxt = M_IDENT;
            cand_nxt = filt('1, c, '0);
          end else begin
            res[res_n] = '{K_UNDEF, 1'b1, to24(p_x), 24'd1, 1'b0, 1'b0};
            res_n = res_n + 2'd1;
          end
        end
      end

      for (int i = 0; i < 3; i++) begin
        if ((2'(i) < res_n) && res[i].is_error) begin
          err_nxt = 1'b1;
        end
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + PB'(1);
      end
    end

    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      cand_r <= '1;
      err_r  <= 1'b0;
    end else if (in_xfer) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      cand_r <= cand_nxt;
      err_r  <= err_nxt;
    end
  end

  // result queue: up to three writes per byte, one read per transfer
  assign in_tready = (cnt_r <= 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_xfer) begin
        wp_r <= wp_r + res_n;
      end
      if (out_xfer) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + (in_xfer ? {1'b0, res_n} : 3'd0) - {2'b00, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < res_n) begin
          q_r[wp_r + 2'(i)] <= res[i];
        end
      end
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {7'd0, q_r[rp_r].any_error, q_r[rp_r].length, q_r[rp_r].offset};
  assign out_tuser  = {q_r[rp_r].is_error, q_r[rp_r].kind};
  assign out_tlast  = q_r[rp_r].last;

endmodule

`default_nettype wire

>>> tb/sv/source_lexical_scanner_checker.sv
// source_lexical_scanner_checker: watches both stream channels of the lexer, predicts tokens
// from accepted source bytes and compares them; depends on sls_pkg for kinds and keywords
`default_nettype none

module source_lexical_scanner_checker
  import sls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,
  input  wire logic [6:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_tokens
);

  typedef enum logic [3:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_NUMDOT, LX_LT, LX_GT, LX_COLON,
    LX_COMMENT, LX_STRING, LX_HALT
  } lex_mode_e;

  localparam logic [23:0] POS_MAX = 24'hFFFFFF;

  lex_mode_e   mode;
  logic [23:0] pos;
  logic [23:0] tok_start;
  logic [31:0] kw_cand;
  logic        err_seen;
  tok_t        step_toks[$];
  tok_t        expected_tokens[$];

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic push_tok(input logic [5:0] kind, input logic err, input logic [23:0] off,
                          input logic [23:0] len, input logic anyerr);
    tok_t t;
    t = '{kind: kind, is_error: err, offset: off, length: len, any_error: anyerr, last: 1'b0};
    if (err) err_seen = 1'b1;
    if (step_toks.size() < 3) step_toks.push_back(t);
  endtask

  // drop keyword candidates whose character at idx differs
  task automatic narrow_keywords(input logic [7:0] c, input logic [23:0] idx);
    for (int k = 0; k < 32; k++) begin
      if (kw_cand[k] && (k >= KW_TABLE || idx >= KW_LEN[k] ||
          KW_TEXT[k][(KW_LEN[k]-1-idx)*8 +: 8] != to_upper(c))) kw_cand[k] = 1'b0;
    end
  endtask

  task automatic push_ident(input logic [23:0] p);
    logic [23:0] len;
    logic [5:0]  kind;
    len = p - tok_start;
    kind = K_IDENT;
    for (int k = KW_TABLE - 1; k >= 0; k--)
      if (kw_cand[k] && KW_LEN[k] == len) kind = 6'(KW_FIRST + k);
    push_tok(kind, 1'b0, tok_start, len, 1'b0);
  endtask

  // fresh scan of a byte from the idle state
  task automatic start_token(input logic [7:0] c, input logic [23:0] p);
    logic [6:0] sym;
    mode = LX_IDLE;
    sym = sym_lookup(c);
    if (sym[6]) begin
      push_tok(sym[5:0], 1'b0, p, 24'd1, 1'b0);
      return;
    end
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    tok_start = p;
    if (c == "<") mode = LX_LT;
    else if (c == ">") mode = LX_GT;
    else if (c == ":") mode = LX_COLON;
    else if (c == "{") mode = LX_COMMENT;
    else if (c == 8'h27) mode = LX_STRING;
    else if (is_dig(c)) mode = LX_NUMBER;
    else if (is_letter(c)) begin
      mode = LX_IDENT;
      kw_cand = 32'h00FF_FFFF;
      narrow_keywords(c, 24'd0);
    end else push_tok(K_UNDEF, 1'b1, p, 24'd1, 1'b0);
  endtask

  task automatic clear_state();
    mode = LX_IDLE;
    pos = '0;
    tok_start = '0;
    kw_cand = 32'h00FF_FFFF;
    err_seen = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] c);
    logic [23:0] p;
    logic        eof_needed;
    p = pos;
    step_toks.delete();
    if (c == 8'd0) begin
      eof_needed = 1'b1;
      case (mode)
        LX_HALT:    eof_needed = 1'b0;
        LX_IDENT:   push_ident(p);
        LX_NUMBER:  push_tok(K_NUMBER, 1'b0, tok_start, p - tok_start, 1'b0);
        LX_NUMDOT:  push_tok(K_UNDEF, 1'b1, tok_start, p - tok_start, 1'b0);
        LX_LT:      push_tok(K_LT, 1'b0, tok_start, 24'd1, 1'b0);
        LX_GT:      push_tok(K_GT, 1'b0, tok_start, 24'd1, 1'b0);
        LX_COLON:   push_tok(K_UNDEF, 1'b1, tok_start, 24'd1, 1'b0);
        LX_COMMENT: begin
          push_tok(K_EOF, 1'b1, tok_start, p - tok_start, 1'b0);
          push_tok(K_COMMENT, 1'b0, tok_start + 24'd1, p - tok_start - 24'd1, 1'b0);
        end
        LX_STRING: begin
          push_tok(K_EOF, 1'b1, tok_start, p - tok_start, 1'b1);
          eof_needed = 1'b0;
        end
        default: ;
      endcase
      if (eof_needed) push_tok(K_EOF, 1'b0, p, 24'd0, err_seen);
      clear_state();
    end else begin
      case (mode)
        LX_IDENT:
          if (is_letter(c) || is_dig(c) || c == "_") narrow_keywords(c, p - tok_start);
          else begin
            push_ident(p);
            start_token(c, p);
          end
        LX_NUMBER:
          if (c == ".") mode = LX_NUMDOT;
          else if (!is_dig(c)) begin
            push_tok(K_NUMBER, 1'b0, tok_start, p - tok_start, 1'b0);
            start_token(c, p);
          end
        LX_NUMDOT:
          if (is_dig(c)) mode = LX_NUMBER;
          else begin
            push_tok(K_UNDEF, 1'b1, tok_start, p - tok_start, 1'b0);
            start_token(c, p);
          end
        LX_LT, LX_GT:
          if (c == "=") begin
            push_tok(mode == LX_LT ? K_LE : K_GE, 1'b0, tok_start, 24'd2, 1'b0);
            mode = LX_IDLE;
          end else begin
            push_tok(mode == LX_LT ? K_LT : K_GT, 1'b0, tok_start, 24'd1, 1'b0);
            start_token(c, p);
          end
        LX_COLON:
          if (c == "=") begin
            push_tok(K_ASSIGN, 1'b0, tok_start, 24'd2, 1'b0);
            mode = LX_IDLE;
          end else begin
            push_tok(K_UNDEF, 1'b1, tok_start, 24'd1, 1'b0);
            start_token(c, p);
          end
        LX_COMMENT:
          if (c == "}") begin
            push_tok(K_COMMENT, 1'b0, tok_start + 24'd1, p - tok_start - 24'd1, 1'b0);
            mode = LX_IDLE;
          end
        LX_STRING:
          if (c == 8'h27) begin
            push_tok(K_STRING, 1'b0, tok_start + 24'd1, p - tok_start - 24'd1, 1'b0);
            mode = LX_IDLE;
          end else if (c == 8'h0D || c == 8'h0A) begin
            push_tok(K_EOL, 1'b1, tok_start, p - tok_start, 1'b1);
            mode = LX_HALT;
          end
        LX_HALT: ;
        default: start_token(c, p);
      endcase
      if (pos < POS_MAX) pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_tokens = 0;
    clear_state();
  end

  always @(posedge clk) begin
    tok_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) report("unexpected token, kind", out_tuser[5:0], 0);
        else begin
          want = expected_tokens.pop_front();
          if (out_tuser[5:0] != want.kind) report("kind", out_tuser[5:0], want.kind);
          if (out_tuser[6] != want.is_error) report("is_error", out_tuser[6], want.is_error);
          if (out_tdata[23:0] != want.offset) report("offset", out_tdata[23:0], want.offset);
          if (out_tdata[47:24] != want.length) report("length", out_tdata[47:24], want.length);
          if (out_tdata[48] != want.any_error) report("any_error", out_tdata[48], want.any_error);
          if (out_tlast != want.last) report("last", out_tlast, want.last);
        end
      end
    end
    pending_tokens = expected_tokens.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/source_lexical_scanner_tb.sv
// source_lexical_scanner_tb: drives source bytes into the lexer with random gaps and stalls
// depends on sls_pkg, source_lexical_scanner and source_lexical_scanner_checker
`default_nettype none

module source_lexical_scanner_tb;
  import sls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [6:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_tokens;
  int          cycle_count;
  logic        gaps_on;
  logic        stalls_on;

  // canned fragments; random sources are stitched from these and random noise
  string frag_lib[$] = '{
    "begin", "END", "EndProcedure", "endfunction", "ENDIF", "endwhile", "ENDLOOP",
    "endploop", "ENDFIT", "endscope", "fit", "Function", "if", "include", "LOOP",
    "ploop", "procedure", "read", "SAVE", "scope", "variable", "while", "write",
    "elseif", "beginx", "x_1", "ab", "IFF", "12", "3.14", "1.2.3", "7.", "0",
    "<", "<=", ">", ">=", ":=", ":", "(", ")", ";", "+", "-", "*", "/", "^", "=",
    "#", "&", "|", "%", "{note}", "{}", "'txt'", "''", " ", "  ", "\t", "\n", "\r",
    "?", "@", "$", "~", ".", "_"
  };

  source_lexical_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] ch
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [23:0] offset, [47:24] length, [48] any_error
    .out_tuser  (out_tuser),   // [5:0] kind, [6] is_error
    .out_tlast  (out_tlast)
  );

  source_lexical_scanner_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** source_lexical_scanner: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls drawn per token
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // one byte transfer, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sample the pending count away from the rising edge, then resync to it
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_tokens != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // random source: mostly well-formed fragments, sometimes separated by blanks, some noise
  task automatic send_random_source(input int pieces);
    int r;
    for (int i = 0; i < pieces; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) send_text(frag_lib[$urandom_range(0, frag_lib.size() - 1)]);
      else send_byte(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 2) == 0) send_byte(" ");
    end
    // occasionally leave an open comment or string at the end
    r = $urandom_range(0, 9);
    if (r == 0) send_text("{open");
    else if (r == 1) send_text("'open");
    else if (r == 2) send_text("'bad\nrest");
    send_byte(8'd0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: back to back, no idling
    send_text("If begin x:=12.5<=3>=a<b>c:d 7.q");
    send_byte(8'd0);
    send_text("{cmt}'s'() ;+-*/^=#&|%?");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'd0);
    send_text("{open");
    send_byte(8'd0);
    send_text("'un");
    send_byte(8'd0);
    send_text("'ab\rxyz");
    send_byte(8'd0);
    send_text("ENDPROCEDURE elseif");
    send_byte(8'd0);

    // full pause until every token has come out
    wait_drained();

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int n = 0; n < 20; n++) begin
      // phases with one side or the other running flat out
      gaps_on   = (n % 4) != 1;
      stalls_on = (n % 4) != 2;
      send_random_source($urandom_range(1, 8));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tokens == 0) $display("** source_lexical_scanner: PASSED **");
    else $display("** source_lexical_scanner: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
